// ----- rtl/lge_pkg.sv -----
// Package for the life generation engine: grid sizes, item and result types,
// controller states and the command and status groups between the modules.
// No dependencies.
`default_nettype none

package lge_pkg;

  // Grid store dimensions and the index widths that follow from them.
  localparam int MAX_ROWS    = 64;
  localparam int MAX_COLUMNS = 64;
  localparam int ROW_AW      = $clog2(MAX_ROWS);
  localparam int COL_AW      = $clog2(MAX_COLUMNS);

  // Field and register widths fixed by the interface.
  localparam int CNT_W = 7;
  localparam int ROW_W = 6;
  localparam int COL_W = 6;

  // Width for comparing row pointers and counts without overflow.
  localparam int CMP_W = ((CNT_W > ROW_AW + 1) ? CNT_W : ROW_AW + 1) + 1;

  // Register reset values.
  localparam logic [CNT_W-1:0] ROW_COUNT_RESET    = 7'd40;
  localparam logic [CNT_W-1:0] COLUMN_COUNT_RESET = 7'd50;

  // Neighbour counts of the B3/S23 rule.
  localparam logic [3:0] SURVIVE_MIN = 4'd2;
  localparam logic [3:0] BIRTH_COUNT = 4'd3;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_STEP  = 2'd2,
    OP_NOP   = 2'd3
  } lge_op_e;

  typedef enum logic {
    REG_ROW_COUNT    = 1'b0,
    REG_COLUMN_COUNT = 1'b1
  } lge_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CELL,
    ST_PRIME,
    ST_ROW
  } lge_state_e;

  // Which result, if any, the datapath registers in this cycle.
  typedef enum logic [1:0] {
    RESP_NONE,
    RESP_ZERO,
    RESP_BAD,
    RESP_CELL
  } lge_resp_e;

  typedef struct packed {
    lge_op_e          op;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] column;
    logic             value;
  } lge_item_t;

  typedef struct packed {
    logic read_value;
    logic bad_address;
  } lge_result_t;

  typedef struct packed {
    logic      load_item;
    logic      rd_input_row;
    logic      step_init;
    logic      step_prime;
    logic      step_row;
    logic      cell_commit;
    lge_resp_e resp;
  } lge_cmd_t;

  typedef struct packed {
    logic addr_ok;
    logic rows_nonzero;
    logic last_row;
  } lge_status_t;

endpackage

`default_nettype wire

// ----- rtl/lge_ctrl.sv -----
// Controller of the life generation engine: sequences cell accesses and the
// row-by-row generation step. Depends on lge_pkg.
`default_nettype none

module lge_ctrl
  import lge_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire lge_op_e     op_i,
  input  wire lge_status_t status_i,
  output lge_cmd_t         cmd_o,
  output logic             busy_o
);

  lge_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          case (op_i)
            OP_WRITE, OP_READ: begin
              if (status_i.addr_ok) state_d = ST_CELL;
            end
            OP_STEP: begin
              if (status_i.rows_nonzero) state_d = ST_PRIME;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_CELL:  state_d = ST_IDLE;
      ST_PRIME: state_d = ST_ROW;
      ST_ROW: begin
        if (status_i.last_row) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd_o = '0;
    cmd_o.resp = RESP_NONE;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          case (op_i)
            OP_WRITE, OP_READ: begin
              if (status_i.addr_ok) begin
                cmd_o.load_item    = 1'b1;
                cmd_o.rd_input_row = 1'b1;
              end else begin
                cmd_o.resp = RESP_BAD;
              end
            end
            OP_STEP: begin
              if (status_i.rows_nonzero) begin
                cmd_o.step_init = 1'b1;
              end else begin
                cmd_o.resp = RESP_ZERO;
              end
            end
            default: cmd_o.resp = RESP_ZERO;
          endcase
        end
      end
      ST_CELL: begin
        cmd_o.cell_commit = 1'b1;
        cmd_o.resp        = RESP_CELL;
      end
      ST_PRIME: cmd_o.step_prime = 1'b1;
      ST_ROW: begin
        cmd_o.step_row = 1'b1;
        if (status_i.last_row) cmd_o.resp = RESP_ZERO;
      end
      default: cmd_o = '0;
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

  // The priming cycle always hands over to the row loop.
  a_prime_to_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_PRIME |=> state_q == ST_ROW)
    else $error("priming cycle not followed by row loop");

  // The last row ends the step.
  a_last_row_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROW && status_i.last_row) |=> state_q == ST_IDLE)
    else $error("step did not end after its last row");

  // A step on a grid with rows starts its priming cycle.
  a_step_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && start_i && op_i == OP_STEP && status_i.rows_nonzero)
    |=> state_q == ST_PRIME)
    else $error("accepted step did not start");

endmodule

`default_nettype wire

// ----- rtl/lge_datapath.sv -----
// Datapath of the life generation engine: size registers, the row-wide grid
// store with per-row valid bits, the three-row window and the rule lanes.
// Depends on lge_pkg.
`default_nettype none

module lge_datapath
  import lge_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire lge_reg_e         cfg_index_i,
  input  wire logic [CNT_W-1:0] cfg_wdata_i,
  input  wire lge_item_t        item_i,
  input  wire lge_cmd_t         cmd_i,
  output lge_status_t           status_o,
  output logic                  done_o,
  output lge_result_t           result_o
);

  logic [CNT_W-1:0]       row_count_q;
  logic [CNT_W-1:0]       column_count_q;
  logic [CMP_W-1:0]       rows_eff;
  logic [CMP_W-1:0]       cols_eff;
  lge_item_t              item_q;
  logic [ROW_AW-1:0]      ptr_q;
  logic [CMP_W-1:0]       ptr_ext;
  logic                   below_ok;
  logic                   next_ok;

  logic [MAX_COLUMNS-1:0] grid_mem [MAX_ROWS];
  logic [MAX_ROWS-1:0]    row_valid_q;
  logic [MAX_COLUMNS-1:0] rd_data_q;
  logic                   rd_valid_q;
  logic [MAX_COLUMNS-1:0] rd_row;
  logic                   rd_en;
  logic [ROW_AW-1:0]      rd_addr;
  logic                   wr_en;
  logic [ROW_AW-1:0]      wr_addr;
  logic [MAX_COLUMNS-1:0] wr_data;
  logic [MAX_COLUMNS-1:0] cell_row;

  logic [MAX_COLUMNS-1:0] above_q;
  logic [MAX_COLUMNS-1:0] cur_q;
  logic [MAX_COLUMNS-1:0] below_g;
  logic [MAX_COLUMNS-1:0] col_mask;
  logic [MAX_COLUMNS-1:0] above_m;
  logic [MAX_COLUMNS-1:0] cur_m;
  logic [MAX_COLUMNS-1:0] below_m;
  logic [MAX_COLUMNS-1:0] new_row;

  logic                   done_q;
  lge_result_t            result_q;

  // Size registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q    <= ROW_COUNT_RESET;
      column_count_q <= COLUMN_COUNT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_ROW_COUNT:    row_count_q    <= cfg_wdata_i;
        REG_COLUMN_COUNT: column_count_q <= cfg_wdata_i;
        default:          row_count_q    <= row_count_q;
      endcase
    end
  end

  // Sizes in use, limited to the store.
  assign rows_eff = (int'(row_count_q) > MAX_ROWS) ? CMP_W'(MAX_ROWS) : CMP_W'(row_count_q);
  assign cols_eff = (int'(column_count_q) > MAX_COLUMNS) ?
                    CMP_W'(MAX_COLUMNS) : CMP_W'(column_count_q);

  // Row pointer checks for the step.
  assign ptr_ext  = CMP_W'(ptr_q);
  assign below_ok = (ptr_ext + CMP_W'(1)) < rows_eff;
  assign next_ok  = (ptr_ext + CMP_W'(2)) < rows_eff;

  assign status_o.addr_ok      = (CMP_W'(item_i.row) < rows_eff) &&
                                 (CMP_W'(item_i.column) < cols_eff);
  assign status_o.rows_nonzero = (rows_eff != '0);
  assign status_o.last_row     = !below_ok;

  // Accepted cell item and step row pointer.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) item_q <= item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
    end else if (cmd_i.step_prime) begin
      ptr_q <= '0;
    end else if (cmd_i.step_row) begin
      ptr_q <= ptr_q + ROW_AW'(1);
    end
  end

  // Store read port: cell row, row 0, row 1, or two rows ahead of the pointer.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    if (cmd_i.rd_input_row) begin
      rd_en   = 1'b1;
      rd_addr = ROW_AW'(item_i.row);
    end else if (cmd_i.step_init) begin
      rd_en   = 1'b1;
      rd_addr = '0;
    end else if (cmd_i.step_prime) begin
      rd_en   = (rows_eff > CMP_W'(1));
      rd_addr = ROW_AW'(1);
    end else if (cmd_i.step_row) begin
      rd_en   = next_ok;
      rd_addr = ptr_q + ROW_AW'(2);
    end
  end

  // A row never written since reset reads as all dead.
  assign rd_row = rd_valid_q ? rd_data_q : '0;

  // Cell write merges the bit into the row just read.
  always_comb begin
    cell_row = rd_row;
    cell_row[COL_AW'(item_q.column)] = item_q.value;
  end

  // Store write port: a cell write or one finished row of a step.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ROW_AW'(item_q.row);
    wr_data = cell_row;
    if (cmd_i.cell_commit && item_q.op == OP_WRITE) begin
      wr_en = 1'b1;
    end else if (cmd_i.step_row) begin
      wr_en   = 1'b1;
      wr_addr = ptr_q;
      wr_data = new_row;
    end
  end

  // Grid store.
  always_ff @(posedge clk_i) begin
    if (wr_en) grid_mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_q <= grid_mem[rd_addr];
  end

  // Row valid bits, cleared at reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      rd_valid_q  <= 1'b0;
    end else begin
      if (wr_en) row_valid_q[wr_addr] <= 1'b1;
      if (rd_en) rd_valid_q <= row_valid_q[rd_addr];
    end
  end

  // Three-row window of old values.
  assign below_g = (cmd_i.step_row && below_ok) ? rd_row : '0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.step_prime) begin
      above_q <= '0;
      cur_q   <= rd_row;
    end else if (cmd_i.step_row) begin
      above_q <= cur_q;
      cur_q   <= below_g;
    end
  end

  // Columns in use; the rest count as dead and keep their bits.
  always_comb begin
    for (int c = 0; c < MAX_COLUMNS; c++) begin
      col_mask[c] = CMP_W'(c) < cols_eff;
    end
  end

  assign above_m = above_q & col_mask;
  assign cur_m   = cur_q & col_mask;
  assign below_m = below_g & col_mask;

  // One rule lane per column.
  always_comb begin
    logic [MAX_COLUMNS-1:0] al, ar, cl, cr, bl, br;
    logic [7:0]             nb;
    logic [3:0]             cnt;
    logic                   alive;
    al = above_m << 1;
    ar = above_m >> 1;
    cl = cur_m << 1;
    cr = cur_m >> 1;
    bl = below_m << 1;
    br = below_m >> 1;
    for (int c = 0; c < MAX_COLUMNS; c++) begin
      nb = {al[c], above_m[c], ar[c], cl[c], cr[c], bl[c], below_m[c], br[c]};
      cnt = 4'($countones(nb));
      alive = cur_m[c] ? (cnt == SURVIVE_MIN || cnt == BIRTH_COUNT) : (cnt == BIRTH_COUNT);
      new_row[c] = col_mask[c] ? alive : cur_q[c];
    end
  end

  // Result beat register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= (cmd_i.resp != RESP_NONE);
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.resp)
      RESP_BAD: begin
        result_q.read_value  <= 1'b0;
        result_q.bad_address <= 1'b1;
      end
      RESP_CELL: begin
        result_q.read_value  <= (item_q.op == OP_READ) && rd_row[COL_AW'(item_q.column)];
        result_q.bad_address <= 1'b0;
      end
      default: begin
        result_q.read_value  <= 1'b0;
        result_q.bad_address <= 1'b0;
      end
    endcase
  end

  assign done_o   = done_q;
  assign result_o = result_q;

  // The store is never read and written at the same row in one cycle.
  a_no_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(rd_en && wr_en && rd_addr == wr_addr))
    else $error("grid store read and write collide");

  // A row is only updated while it lies inside the configured rows.
  a_row_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step_row |-> ptr_ext < rows_eff)
    else $error("step row pointer beyond configured rows");

  // A cell commit always follows the read of its row.
  a_commit_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cell_commit |-> $past(cmd_i.rd_input_row))
    else $error("cell commit without a preceding row read");

endmodule

`default_nettype wire

// ----- rtl/life_generation_engine.sv -----
// Top level of the life generation engine: joins controller and datapath.
// Depends on lge_pkg, lge_ctrl and lge_datapath.
`default_nettype none

// B3/S23 cellular automaton on a grid of up to 64 by 64 cells.
// Command channel: an item (op, row, column, value) is taken at a rising
// edge with start_i high and busy_o low. Each item gives one result beat on
// result_o, marked by done_o for exactly one cycle; the receiver cannot
// stall, so every beat must be taken when shown.
// Sequence: a bad address, a no-op or a step on zero rows gives its beat in
// the cycle after acceptance, and busy_o stays low. A cell read or write
// first reads the cell's row from the store, then merges or selects the
// bit. A generation step fetches row 0, then row 1, then updates one row
// per cycle, all columns of the row in parallel from a three-row window,
// while the row two ahead is read. The single read and write port of the
// row-wide store sets this order.
// Configuration: cfg_we_i writes row_count (index 0) or column_count
// (index 1) from cfg_wdata_i at once; write only while busy_o is low.
// Reset: sizes return to 40 rows and 50 columns; per-row valid bits clear
// so the whole grid reads as dead at once, with no clearing pass.

module life_generation_engine
  import lge_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire lge_reg_e         cfg_index_i,
  input  wire logic [CNT_W-1:0] cfg_wdata_i,
  input  wire logic             start_i,
  input  wire lge_item_t        item_i,
  output logic                  busy_o,
  output logic                  done_o,
  output lge_result_t           result_o
);

  lge_cmd_t    cmd;
  lge_status_t status;

  // Sequencer.
  lge_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .op_i     (item_i.op),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  // Store, window and rule lanes.
  lge_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_i      (item_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .done_o      (done_o),
    .result_o    (result_o)
  );

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
// Self-checking testbench for the life generation engine: a queue-fed command driver,
// a result monitor and a cell-grid predictor, with several grid sizes and idle patterns.
// Depends on lge_pkg and life_generation_engine.
`timescale 1ns / 100ps

module testbench
  import lge_pkg::*;
();

  localparam int TIMEOUT_NS       = 2_000_000;
  localparam int SETTLE_CYCLES    = MAX_ROWS + 8;
  localparam int SURVIVE_LOW      = 2;
  localparam int BIRTH_NEIGHBOURS = 3;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             cfg_we_i    = 1'b0;
  lge_reg_e         cfg_index_i = REG_ROW_COUNT;
  logic [CNT_W-1:0] cfg_wdata_i = '0;
  logic             start_i     = 1'b0;
  lge_item_t        item_i      = '0;
  logic             busy_o;
  logic             done_o;
  lge_result_t      result_o;

  // Predictor state: the grid as it should be and the sizes written so far.
  logic [MAX_COLUMNS-1:0] life_grid [MAX_ROWS];
  logic [CNT_W-1:0]       row_limit;
  logic [CNT_W-1:0]       col_limit;

  lge_item_t   pending_items [$];
  lge_result_t cell_results [$];
  int          idle_pct   = 0;
  int          fail_count = 0;

  life_generation_engine dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .start_i     (start_i),
    .item_i      (item_i),
    .busy_o      (busy_o),
    .done_o      (done_o),
    .result_o    (result_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Sizes above the store's maximum behave as the maximum.
  function automatic int active_rows();
    return (int'(row_limit) > MAX_ROWS) ? MAX_ROWS : int'(row_limit);
  endfunction

  function automatic int active_cols();
    return (int'(col_limit) > MAX_COLUMNS) ? MAX_COLUMNS : int'(col_limit);
  endfunction

  // One B3/S23 generation over the rows and columns in use, computed from a
  // snapshot of the old grid. Cells outside the used area keep their bits.
  function automatic void advance_generation();
    logic [MAX_COLUMNS-1:0] prev [MAX_ROWS];
    int rows;
    int cols;
    int live;
    rows = active_rows();
    cols = active_cols();
    prev = life_grid;
    for (int r = 0; r < rows; r++) begin
      for (int c = 0; c < cols; c++) begin
        live = 0;
        for (int dr = -1; dr <= 1; dr++) begin
          for (int dc = -1; dc <= 1; dc++) begin
            if ((dr != 0 || dc != 0) && r + dr >= 0 && r + dr < rows &&
                c + dc >= 0 && c + dc < cols) begin
              live += int'(prev[r + dr][c + dc]);
            end
          end
        end
        if (prev[r][c]) begin
          life_grid[r][c] = (live == SURVIVE_LOW || live == BIRTH_NEIGHBOURS);
        end else begin
          life_grid[r][c] = (live == BIRTH_NEIGHBOURS);
        end
      end
    end
  endfunction

  // Applies one accepted command to the predicted grid and returns its beat.
  function automatic lge_result_t apply_item(lge_item_t it);
    lge_result_t res;
    res = '0;
    case (it.op)
      OP_WRITE, OP_READ: begin
        if (int'(it.row) >= active_rows() || int'(it.column) >= active_cols()) begin
          res.bad_address = 1'b1;
        end else if (it.op == OP_WRITE) begin
          life_grid[it.row][it.column] = it.value;
        end else begin
          res.read_value = life_grid[it.row][it.column];
        end
      end
      OP_STEP: advance_generation();
      default: ;
    endcase
    return res;
  endfunction

  // Command driver: records the expected beat at acceptance; while no command is
  // held waiting on busy_o, it presents the next pending command or idles.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        cell_results.push_back(apply_item(item_i));
      end
      if (!start_i || !busy_o) begin
        if (pending_items.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
          item_i  <= pending_items.pop_front();
          start_i <= 1'b1;
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor: every beat is compared with the oldest expectation.
  always @(posedge clk_i) begin : result_check
    lge_result_t want;
    if (rst_ni && done_o) begin
      if (cell_results.size() == 0) begin
        $error("unexpected result beat: read_value %0b, bad_address %0b",
               result_o.read_value, result_o.bad_address);
        fail_count++;
      end else begin
        want = cell_results.pop_front();
        if (result_o.read_value !== want.read_value) begin
          $error("read_value: expected %0b, got %0b", want.read_value, result_o.read_value);
          fail_count++;
        end
        if (result_o.bad_address !== want.bad_address) begin
          $error("bad_address: expected %0b, got %0b", want.bad_address,
                 result_o.bad_address);
          fail_count++;
        end
      end
    end
  end

  task automatic plan_item(lge_op_e op, int row, int col, bit val);
    lge_item_t it;
    it.op     = op;
    it.row    = ROW_W'(row);
    it.column = COL_W'(col);
    it.value  = val;
    pending_items.push_back(it);
  endtask

  // Waits until every command has been sent and answered and the block is idle.
  task automatic wait_idle();
    do begin
      @(negedge clk_i);
    end while (pending_items.size() != 0 || start_i || cell_results.size() != 0 || busy_o);
    repeat (4) @(negedge clk_i);
  endtask

  // Writes both size registers while idle and moves to a new idle pattern.
  task automatic run_phase(int rows, int cols, int pct);
    wait_idle();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_ROW_COUNT;
    cfg_wdata_i <= CNT_W'(rows);
    @(posedge clk_i);
    cfg_index_i <= REG_COLUMN_COUNT;
    cfg_wdata_i <= CNT_W'(cols);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    row_limit = CNT_W'(rows);
    col_limit = CNT_W'(cols);
    @(negedge clk_i);
    idle_pct = pct;
  endtask

  // Fills the whole used area with a random soup, evolves it and reads it all back.
  task automatic plan_soup(int steps);
    for (int r = 0; r < active_rows(); r++) begin
      for (int c = 0; c < active_cols(); c++) begin
        plan_item(OP_WRITE, r, c, $urandom_range(0, 99) < 40);
      end
    end
    repeat (steps) plan_item(OP_STEP, 0, 0, 0);
    for (int r = 0; r < active_rows(); r++) begin
      for (int c = 0; c < active_cols(); c++) begin
        plan_item(OP_READ, r, c, 1'($urandom_range(0, 1)));
      end
    end
  endtask

  // Random mix: mostly in-range writes and reads with some generation steps,
  // plus out-of-range accesses and the unused op code.
  task automatic plan_random(int count);
    int        pick;
    int        rows;
    int        cols;
    lge_item_t it;
    rows = active_rows();
    cols = active_cols();
    for (int n = 0; n < count; n++) begin
      pick      = $urandom_range(0, 99);
      it.op     = OP_NOP;
      it.row    = ROW_W'($urandom_range(0, MAX_ROWS - 1));
      it.column = COL_W'($urandom_range(0, MAX_COLUMNS - 1));
      it.value  = 1'($urandom_range(0, 1));
      if (pick < 72 && rows > 0 && cols > 0) begin
        it.op     = (pick < 40) ? OP_WRITE : OP_READ;
        it.row    = ROW_W'($urandom_range(0, rows - 1));
        it.column = COL_W'($urandom_range(0, cols - 1));
        if (pick < 40) begin
          it.value = ($urandom_range(0, 99) < 40);
        end
      end else if (pick < 80) begin
        it.op = OP_STEP;
      end else if (pick < 92) begin
        it.op = pick[0] ? OP_WRITE : OP_READ;
        if ($urandom_range(0, 1) == 1 && rows < MAX_ROWS) begin
          it.row = ROW_W'($urandom_range(rows, MAX_ROWS - 1));
        end else if (cols < MAX_COLUMNS) begin
          it.column = COL_W'($urandom_range(cols, MAX_COLUMNS - 1));
        end else if (rows < MAX_ROWS) begin
          it.row = ROW_W'($urandom_range(rows, MAX_ROWS - 1));
        end
      end
      pending_items.push_back(it);
    end
  endtask

  // Main sequence.
  initial begin
    foreach (life_grid[r]) life_grid[r] = '0;
    row_limit = ROW_COUNT_RESET;
    col_limit = COLUMN_COUNT_RESET;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed commands at the reset size of 40 by 50.
    plan_item(OP_READ, 0, 0, 0);
    plan_item(OP_READ, 39, 49, 1);
    plan_item(OP_WRITE, 0, 0, 1);
    plan_item(OP_READ, 0, 0, 0);
    plan_item(OP_WRITE, 39, 49, 1);
    plan_item(OP_READ, 39, 49, 0);
    plan_item(OP_WRITE, 40, 0, 1);
    plan_item(OP_READ, 0, 50, 0);
    plan_item(OP_WRITE, 63, 63, 1);
    plan_item(OP_READ, 63, 0, 1);
    plan_item(OP_NOP, 63, 63, 1);
    plan_item(OP_STEP, 0, 0, 0);
    plan_item(OP_READ, 0, 0, 0);
    // A blinker, and a cell written alive then dead again.
    plan_item(OP_WRITE, 10, 10, 1);
    plan_item(OP_WRITE, 10, 11, 1);
    plan_item(OP_WRITE, 10, 12, 1);
    plan_item(OP_WRITE, 20, 20, 1);
    plan_item(OP_WRITE, 20, 20, 0);
    plan_item(OP_STEP, 63, 63, 1);
    plan_item(OP_READ, 9, 11, 0);
    plan_item(OP_READ, 10, 11, 0);
    plan_item(OP_READ, 11, 11, 0);
    plan_item(OP_READ, 10, 10, 0);
    plan_item(OP_READ, 20, 20, 0);
    plan_item(OP_STEP, 0, 0, 0);
    plan_item(OP_READ, 10, 12, 0);

    run_phase(6, 6, 73);
    plan_soup(3);
    plan_random(15);

    run_phase(64, 64, 0);
    plan_random(60);

    // Sizes above the maximum act as the maximum.
    run_phase(127, 127, 22);
    plan_random(50);

    // With zero rows or zero columns every access is flagged.
    run_phase(0, 50, 73);
    plan_random(20);

    run_phase(5, 0, 0);
    plan_random(15);

    run_phase(1, 1, 22);
    plan_random(20);

    run_phase(3, 65, 73);
    plan_random(40);

    // Hold the sender off until every beat is back before the random tail.
    run_phase(5, 8, 0);
    plan_soup(2);
    wait_idle();
    plan_random(20);

    run_phase($urandom_range(1, 127), $urandom_range(1, 127), 22);
    plan_random(50);

    // Back to the reset size: cells outside earlier sizes must have kept their bits.
    run_phase(40, 50, 73);
    plan_random(40);

    wait_idle();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog for a block that stops answering.
  initial begin
    #(TIMEOUT_NS);
    $display("FAILED: results differ");
    $finish;
  end

endmodule
